>>> src/ffqcs_pkg.sv
// Package: shared types and constants of the flow fair-queue class selector.
`timescale 1ns / 1ps
package ffqcs_pkg;

  localparam int unsigned FLOWS_DEF = 16;
  localparam int unsigned WGHT_MIN  = 3;
  localparam int unsigned WGHT_MAX  = 256;
  localparam int unsigned DIV_W     = 64;

  // floor(x / 100) == (x * MD_RECIP) >> MD_SHIFT for x below 2^27
  localparam longint unsigned MD_RECIP = 64'd171798692;
  localparam int unsigned     MD_SHIFT = 34;

  // request types
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_DONE  = 2'd1;
  localparam logic [1:0] REQ_IDLE  = 2'd2;
  localparam logic [1:0] REQ_TICK  = 2'd3;

  // service classes
  localparam logic [1:0] CLS_LOW  = 2'd0;
  localparam logic [1:0] CLS_MED  = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;
  localparam logic [1:0] CLS_NONE = 2'd3;

  // register indexes
  localparam logic [1:0] REG_THR   = 2'd0;
  localparam logic [1:0] REG_RATIO = 2'd1;
  localparam logic [1:0] REG_DYN   = 2'd2;

  typedef struct packed {
    logic [63:0] vtime;
    logic [63:0] vprev;
    logic [15:0] inflight;
    logic [31:0] u_high;
    logic [31:0] u_med;
    logic [31:0] u_low;
  } flow_entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

>>> src/ffqcs_flow_tbl.sv
// Flow table: one-read, one-write memory of flow records with per-entry valid bits.
`timescale 1ns / 1ps
module ffqcs_flow_tbl #(
  parameter int unsigned FLOWS = ffqcs_pkg::FLOWS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [$clog2(FLOWS)-1:0]  raddr_i,
  output ffqcs_pkg::flow_entry_t    rdata_o,
  input  logic                      we_i,
  input  logic [$clog2(FLOWS)-1:0]  waddr_i,
  input  ffqcs_pkg::flow_entry_t    wdata_i
);
  import ffqcs_pkg::*;

  flow_entry_t      mem_q [FLOWS];
  flow_entry_t      rd_q;
  logic [FLOWS-1:0] valid_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
    end
  end

  // never-written entries read as the reset value
  assign rdata_o = rd_valid_q ? rd_q : '0;

endmodule

>>> src/ffqcs_divider.sv
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module ffqcs_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ffqcs_pkg::DIV_W-1:0]   num_i,
  input  logic [ffqcs_pkg::DIV_W-1:0]   den_i,
  output logic [ffqcs_pkg::DIV_W-1:0]   quo_o,
  output logic [ffqcs_pkg::DIV_W-1:0]   rem_o,
  output ffqcs_pkg::div_sts_t           sts_o
);
  import ffqcs_pkg::*;

  localparam int unsigned CntW = $clog2(DIV_W);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q, quo_q, den_q;
  logic [DIV_W:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_q, quo_q[DIV_W-1]};
  assign diff = sh - {1'b0, den_q};
  assign ge   = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;
  assign sts_o = '{busy: busy_q, done: done_q};

endmodule

>>> src/flow_fair_queue_class_select.sv
// Start reads each flow in turn through the table's single read port and writes one back;
// completion and idle read and act on one entry; tick with dynamic weight off goes straight to
// the result. Tick with it on: setup, a read and usage clear per flow, three passes of the
// 64-step shared divider per flow with usage, a decision and, if needed, a weight rescale.
// One transaction at a time; a finished result waits in the output register while the
// next one runs. Reset: table entries read as zero through valid bits, no flow active, weight 3.
`timescale 1ns / 1ps
module flow_fair_queue_class_select #(
  parameter int unsigned FLOWS = ffqcs_pkg::FLOWS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  flow_id_i,
  input  logic [1:0]  done_class_i,
  input  logic [23:0] data_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  service_class_o,
  output logic        idle_arm_o,
  output logic        weight_changed_o,
  output logic [8:0]  new_weight_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffqcs_pkg::*;

  localparam int unsigned IdxW    = $clog2(FLOWS);
  localparam int unsigned CntW    = $clog2(FLOWS + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FLOWS - 1);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_ST_RD = 5'd1;
  localparam logic [4:0] S_ST_CMP = 5'd2;
  localparam logic [4:0] S_ST_FIN = 5'd3;
  localparam logic [4:0] S_X_RD  = 5'd4;
  localparam logic [4:0] S_X_USE = 5'd5;
  localparam logic [4:0] S_T_LW  = 5'd6;
  localparam logic [4:0] S_T_LWW = 5'd7;
  localparam logic [4:0] S_T_SQ  = 5'd8;
  localparam logic [4:0] S_T_WGT = 5'd9;
  localparam logic [4:0] S_T_RD  = 5'd10;
  localparam logic [4:0] S_T_USE = 5'd11;
  localparam logic [4:0] S_T_D1  = 5'd12;
  localparam logic [4:0] S_T_D1W = 5'd13;
  localparam logic [4:0] S_T_D2  = 5'd14;
  localparam logic [4:0] S_T_D2W = 5'd15;
  localparam logic [4:0] S_T_D3  = 5'd16;
  localparam logic [4:0] S_T_D3W = 5'd17;
  localparam logic [4:0] S_T_NEXT = 5'd18;
  localparam logic [4:0] S_T_DEC = 5'd19;
  localparam logic [4:0] S_T_SCW = 5'd20;
  localparam logic [4:0] S_T_SCL = 5'd21;
  localparam logic [4:0] S_T_SCF = 5'd22;
  localparam logic [4:0] S_T_APPLY = 5'd23;
  localparam logic [4:0] S_DONE  = 5'd24;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  logic [4:0] state_q, state_d;

  // configuration
  logic [19:0] thr_q;
  logic [6:0]  ratio_q;
  logic        dyn_q;
  logic [6:0]  ratio_c;
  logic [26:0] mdx_q;
  logic [19:0] md_q;
  logic        cfg_we;

  // transaction
  logic [1:0]  req_q, cls_q;
  logic [3:0]  id_q;
  logic [23:0] len_q;
  logic        accept, id_ok;
  logic [IdxW-1:0] idx_q, id_addr;

  // flow state outside the table
  logic [FLOWS-1:0] active_q;
  logic [CntW-1:0]  act_cnt_q;
  logic [8:0]       cw_q;

  // start scan
  logic [63:0] min_q;
  logic        any_q;
  flow_entry_t cap_q;
  logic [63:0] gap;
  logic [CntW-1:0] cnt_after;

  // tick datapath
  logic [8:0]  lw_q;
  logic [4:0]  sqb_q;
  logic [17:0] mw_q, hw_q;
  logic [49:0] prod_q;
  logic [31:0] l_q;
  logic [33:0] t_q, t_c;
  logic [34:0] ht1_q;
  logic [63:0] sum_q;
  logic [63:0] max_vt_q, max_per_q, min_vt_q, min_per_q, max_slow_q;
  logic        have_min_q, max_chk_q;
  logic [8:0]  next_q;
  logic [7:0]  scq_q;
  logic [63:0] dr_q, rr_q, acc_q;
  logic [8:0]  squo_q, k_q;
  logic [17:0] sc_res;
  logic        c1, c2, dec_div;

  // results
  logic [1:0] svc_q;
  logic       arm_q, chg_q;
  logic       out_valid_q, out_arm_q, out_chg_q;
  logic [1:0] out_svc_q;
  logic [8:0] out_wgt_q;

  // table and divider hookup
  logic [IdxW-1:0] tbl_raddr, tbl_waddr;
  logic            tbl_we;
  flow_entry_t     tbl_rdata, tbl_wdata;
  logic            div_start;
  logic [63:0]     div_num, div_den, div_quo, div_rem;
  div_sts_t        div_sts;

  ffqcs_flow_tbl #(.FLOWS(FLOWS)) u_tbl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata)
  );

  ffqcs_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .sts_o   (div_sts)
  );

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= 20'd8192;
      ratio_q <= 7'd70;
      dyn_q   <= 1'b0;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_THR:   thr_q   <= pwdata[19:0];
        REG_RATIO: ratio_q <= pwdata[6:0];
        REG_DYN:   dyn_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THR:   prdata = {12'd0, thr_q};
      REG_RATIO: prdata = {25'd0, ratio_q};
      REG_DYN:   prdata = {31'd0, dyn_q};
      default:   prdata = '0;
    endcase
  end

  // medium boundary thr*(100-ratio)/100, two multiplier stages
  assign ratio_c = (ratio_q > 7'd100) ? 7'd100 : ratio_q;
  always_ff @(posedge clk_i) begin
    mdx_q <= 27'(thr_q) * 27'(7'd100 - ratio_c);
    md_q  <= 20'((55'(mdx_q) * 55'(MD_RECIP)) >> MD_SHIFT);
  end

  // ---------------- control ----------------
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign id_ok      = (9'(flow_id_i) < 9'(FLOWS));
  assign id_addr    = IdxW'(id_q);

  assign gap       = active_q[id_addr] ? (cap_q.vtime - min_q) : 64'd0;
  assign cnt_after = active_q[id_addr] ? act_cnt_q : act_cnt_q + 1'b1;
  assign t_c       = 34'(tbl_rdata.u_high) + 34'(tbl_rdata.u_med) + 34'(tbl_rdata.u_low);

  assign c1 = (max_slow_q < 64'(cw_q)) && (cw_q > 9'(WGHT_MIN));
  assign c2 = have_min_q && (max_vt_q > min_vt_q) &&
              ((max_vt_q - min_vt_q) > 64'({thr_q, 1'b0})) && max_chk_q &&
              (cw_q < 9'(WGHT_MAX)) && (max_per_q > min_per_q);
  assign dec_div = (act_cnt_q >= CntW'(2)) && !c1 && c2 && (min_per_q != 64'd0);

  assign sc_res = 18'(scq_q) * 18'(cw_q) + 18'(squo_q) + 18'(acc_q != 64'd0);

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    tbl_raddr = idx_q;
    tbl_we    = 1'b0;
    tbl_waddr = id_addr;
    tbl_wdata = tbl_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_TICK) begin
            state_d = dyn_q ? S_T_LW : S_DONE;
          end else if (!id_ok) begin
            state_d = S_DONE;
          end else if (req_type_i == REQ_START) begin
            state_d = S_ST_RD;
          end else begin
            state_d = S_X_RD;
          end
        end
      end
      S_ST_RD:  state_d = S_ST_CMP;
      S_ST_CMP: state_d = (idx_q == IdxLast) ? S_ST_FIN : S_ST_RD;
      S_ST_FIN: begin
        tbl_we    = 1'b1;
        tbl_wdata = cap_q;
        if (!active_q[id_addr]) begin
          tbl_wdata.vtime = min_q;
          tbl_wdata.vprev = min_q;
        end
        if (cap_q.inflight != 16'hFFFF) begin
          tbl_wdata.inflight = cap_q.inflight + 16'd1;
        end
        state_d = S_DONE;
      end
      S_X_RD: begin
        tbl_raddr = id_addr;
        state_d   = S_X_USE;
      end
      S_X_USE: begin
        if (req_q == REQ_DONE) begin
          tbl_we = 1'b1;
          unique case (cls_q)
            CLS_LOW:  tbl_wdata.u_low  = sat_add32(tbl_rdata.u_low, 32'(len_q[23:10]));
            CLS_MED:  tbl_wdata.u_med  = sat_add32(tbl_rdata.u_med, 32'(len_q[23:10]));
            CLS_HIGH: tbl_wdata.u_high = sat_add32(tbl_rdata.u_high, 32'(len_q[23:10]));
            CLS_NONE: ;
            default: ;
          endcase
          tbl_wdata.vtime = tbl_rdata.vtime + 64'(len_q[23:10]);
          if (tbl_rdata.inflight != 16'd0) begin
            tbl_wdata.inflight = tbl_rdata.inflight - 16'd1;
          end
        end
        state_d = S_DONE;
      end
      S_T_LW: begin
        div_start = 1'b1;
        div_num   = 64'(WGHT_MAX);
        div_den   = 64'(cw_q);
        state_d   = S_T_LWW;
      end
      S_T_LWW: if (div_sts.done) state_d = S_T_SQ;
      S_T_SQ: begin
        if (!(10'(sqb_q) * 10'(sqb_q) < 10'(cw_q))) state_d = S_T_WGT;
      end
      S_T_WGT: state_d = S_T_RD;
      S_T_RD:  state_d = S_T_USE;
      S_T_USE: begin
        tbl_we           = 1'b1;
        tbl_waddr        = idx_q;
        tbl_wdata.u_high = '0;
        tbl_wdata.u_med  = '0;
        tbl_wdata.u_low  = '0;
        tbl_wdata.vprev  = tbl_rdata.vtime;
        state_d = (t_c == 34'd0) ? S_T_NEXT : S_T_D1;
      end
      S_T_D1: begin
        div_start = 1'b1;
        div_num   = 64'(prod_q);
        div_den   = 64'(mw_q);
        state_d   = S_T_D1W;
      end
      S_T_D1W: if (div_sts.done) state_d = S_T_D2;
      S_T_D2: begin
        div_start = 1'b1;
        div_num   = 64'(prod_q);
        div_den   = 64'(lw_q);
        state_d   = S_T_D2W;
      end
      S_T_D2W: if (div_sts.done) state_d = S_T_D3;
      S_T_D3: begin
        div_start = 1'b1;
        div_num   = sum_q;
        div_den   = 64'(t_q);
        state_d   = S_T_D3W;
      end
      S_T_D3W:  if (div_sts.done) state_d = S_T_NEXT;
      S_T_NEXT: state_d = (idx_q == IdxLast) ? S_T_DEC : S_T_RD;
      S_T_DEC: begin
        if (dec_div) begin
          div_start = 1'b1;
          div_num   = max_per_q;
          div_den   = min_per_q;
          state_d   = S_T_SCW;
        end else begin
          state_d = S_T_APPLY;
        end
      end
      S_T_SCW: begin
        if (div_sts.done) begin
          state_d = (div_quo >= 64'(WGHT_MAX)) ? S_T_APPLY : S_T_SCL;
        end
      end
      S_T_SCL:   if (k_q == cw_q - 9'd1) state_d = S_T_SCF;
      S_T_SCF:   state_d = S_T_APPLY;
      S_T_APPLY: state_d = S_DONE;
      S_DONE:    if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      act_cnt_q   <= '0;
      cw_q        <= 9'(WGHT_MIN);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_ST_FIN: begin
          if (!active_q[id_addr]) begin
            active_q[id_addr] <= 1'b1;
            act_cnt_q         <= cnt_after;
          end
        end
        S_X_USE: begin
          if (req_q == REQ_IDLE && tbl_rdata.inflight == 16'd0 && active_q[id_addr]) begin
            active_q[id_addr] <= 1'b0;
            if (act_cnt_q != '0) act_cnt_q <= act_cnt_q - 1'b1;
          end
        end
        S_T_APPLY: begin
          if (next_q != 9'd0 && next_q != cw_q) cw_q <= next_q;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) out_valid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_q      <= req_type_i;
          id_q       <= flow_id_i;
          cls_q      <= done_class_i;
          len_q      <= data_len_i;
          svc_q      <= CLS_LOW;
          arm_q      <= 1'b0;
          chg_q      <= 1'b0;
          idx_q      <= '0;
          min_q      <= '0;
          any_q      <= 1'b0;
          max_vt_q   <= '0;
          max_per_q  <= '0;
          min_vt_q   <= '0;
          min_per_q  <= '0;
          have_min_q <= 1'b0;
          max_slow_q <= '0;
          max_chk_q  <= 1'b0;
          next_q     <= '0;
        end
      end
      S_ST_CMP: begin
        if (active_q[idx_q] && (!any_q || tbl_rdata.vtime < min_q)) begin
          min_q <= tbl_rdata.vtime;
          any_q <= 1'b1;
        end
        if (idx_q == id_addr) cap_q <= tbl_rdata;
        if (idx_q != IdxLast) idx_q <= idx_q + 1'b1;
      end
      S_ST_FIN: begin
        // a sole active flow always answers medium
        priority if (cnt_after == CntW'(1)) svc_q <= CLS_MED;
        else if (gap > 64'(thr_q))         svc_q <= CLS_LOW;
        else if (gap > 64'(md_q))          svc_q <= CLS_MED;
        else                               svc_q <= CLS_HIGH;
      end
      S_X_USE: begin
        if (req_q == REQ_DONE) arm_q <= (tbl_rdata.inflight <= 16'd1);
      end
      S_T_LWW: begin
        if (div_sts.done) begin
          lw_q  <= 9'(div_quo);
          sqb_q <= '0;
        end
      end
      S_T_SQ: begin
        if (10'(sqb_q) * 10'(sqb_q) < 10'(cw_q)) sqb_q <= sqb_q + 5'd1;
      end
      S_T_WGT: begin
        mw_q <= 18'(lw_q) * 18'(sqb_q);
        hw_q <= 18'(lw_q) * 18'(cw_q);
      end
      S_T_USE: begin
        if (t_c != 34'd0) begin
          if (max_vt_q < tbl_rdata.vtime) begin
            max_vt_q  <= tbl_rdata.vtime;
            max_per_q <= tbl_rdata.vtime - tbl_rdata.vprev;
          end
          if (active_q[idx_q] && (!have_min_q || tbl_rdata.vtime < min_vt_q)) begin
            have_min_q <= 1'b1;
            min_vt_q   <= tbl_rdata.vtime;
            min_per_q  <= tbl_rdata.vtime - tbl_rdata.vprev;
          end
        end
        prod_q <= 50'(tbl_rdata.u_med) * 50'(hw_q);
        l_q    <= tbl_rdata.u_low;
        t_q    <= t_c;
        ht1_q  <= 35'(tbl_rdata.u_high) + 35'(t_c) - 35'd1;
      end
      S_T_D1W: begin
        if (div_sts.done) begin
          sum_q  <= 64'(ht1_q) + div_quo;
          prod_q <= 50'(l_q) * 50'(hw_q);
        end
      end
      S_T_D2W: if (div_sts.done) sum_q <= sum_q + div_quo;
      S_T_D3W: begin
        if (div_sts.done && max_slow_q < div_quo) begin
          max_slow_q <= div_quo;
          max_chk_q  <= (34'({l_q, 1'b0}) >= t_q);
        end
      end
      S_T_NEXT: if (idx_q != IdxLast) idx_q <= idx_q + 1'b1;
      S_T_DEC: begin
        priority if (act_cnt_q < CntW'(2)) next_q <= '0;
        else if (c1) next_q <= (max_slow_q < 64'(WGHT_MIN)) ? 9'(WGHT_MIN) : 9'(max_slow_q);
        else if (c2) next_q <= (min_per_q == 64'd0) ? 9'(WGHT_MAX) : 9'd0;
        else         next_q <= '0;
      end
      S_T_SCW: begin
        if (div_sts.done) begin
          next_q <= 9'(WGHT_MAX);
          scq_q  <= 8'(div_quo);
          dr_q   <= min_per_q - div_rem;
          rr_q   <= div_rem;
          acc_q  <= '0;
          squo_q <= '0;
          k_q    <= '0;
        end
      end
      S_T_SCL: begin
        // remainder scaled by the weight, one step per cycle
        if (acc_q >= dr_q) begin
          acc_q  <= acc_q - dr_q;
          squo_q <= squo_q + 9'd1;
        end else begin
          acc_q <= acc_q + rr_q;
        end
        k_q <= k_q + 9'd1;
      end
      S_T_SCF: next_q <= (sc_res > 18'(WGHT_MAX)) ? 9'(WGHT_MAX) : 9'(sc_res);
      S_T_APPLY: chg_q <= (next_q != 9'd0) && (next_q != cw_q);
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_svc_q <= svc_q;
          out_arm_q <= arm_q;
          out_chg_q <= chg_q;
          out_wgt_q <= cw_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign service_class_o  = out_svc_q;
  assign idle_arm_o       = out_arm_q;
  assign weight_changed_o = out_chg_q;
  assign new_weight_o     = out_wgt_q;

`ifndef SYNTHESIS
  a_cnt_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_cnt_q == CntW'($countones(active_q)))
    else $error("active count out of step with active flags");
  a_wgt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_q >= 9'(WGHT_MIN) && cw_q <= 9'(WGHT_MAX))
    else $error("class weight out of range");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");
  a_chg_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_chg_q) |-> (out_svc_q == CLS_LOW && !out_arm_q))
    else $error("weight change flagged on a non-tick transaction");
`endif

endmodule
